[hw/rtl/tdpt_pkg.sv]
// trial division prime test: shared constants and controller/datapath types
// no dependencies
package tdpt_pkg;

    localparam int NUM_WIDTH_DEF = 32;
    localparam int FIRST_DIVISOR = 2;

    typedef struct packed {
        logic load;
        logic step;
        logic next;
    } cmd_t;

    typedef struct packed {
        logic too_low;
        logic div_last;
        logic bound_fail;
        logic rem_zero;
    } status_t;

endpackage

[hw/rtl/tdpt_datapath.sv]
// trial division datapath: candidate, divisor and a radix-2 restoring divider
// depends on tdpt_pkg
module tdpt_datapath #(
    parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [NUM_WIDTH-1:0] s_candidate,
    input  tdpt_pkg::cmd_t       cmd,
    output tdpt_pkg::status_t    status
);

    localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] value_reg;
    logic [NUM_WIDTH-1:0] div_reg;
    logic [NUM_WIDTH:0]   rem_reg;
    logic [NUM_WIDTH-1:0] quo_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;

    logic [NUM_WIDTH:0]   rem_shift;
    logic [NUM_WIDTH:0]   div_ext;
    logic                 ge;
    logic [NUM_WIDTH:0]   rem_next;

    assign rem_shift = {rem_reg[NUM_WIDTH-1:0], quo_reg[NUM_WIDTH-1]};
    assign div_ext   = {1'b0, div_reg};
    assign ge        = rem_shift >= div_ext;
    assign rem_next  = ge ? rem_shift - div_ext : rem_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            value_reg <= s_candidate;
            div_reg   <= NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
            rem_reg   <= '0;
            quo_reg   <= s_candidate;
            cnt_reg   <= '0;
        end else if (cmd.next) begin
            div_reg <= div_reg + NUM_WIDTH'(1);
            rem_reg <= '0;
            quo_reg <= value_reg;
            cnt_reg <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_WIDTH-2:0], ge};
            cnt_reg <= cnt_reg + CNT_WIDTH'(1);
        end
    end

    assign status.too_low    = value_reg < NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
    assign status.div_last   = cnt_reg == CNT_WIDTH'(NUM_WIDTH - 1);
    assign status.bound_fail = quo_reg < div_reg;
    assign status.rem_zero   = rem_reg == '0;

endmodule

[hw/rtl/tdpt_ctrl.sv]
// trial division controller: handshakes, divide sequencing, result register
// depends on tdpt_pkg
module tdpt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_prime,
    output tdpt_pkg::cmd_t    cmd,
    input  tdpt_pkg::status_t status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       is_prime_reg;
    logic       is_prime_next;

    logic out_free;
    logic finish;
    logic result;

    assign out_free = !m_valid_reg || m_ready;
    assign finish   = status.too_low || status.bound_fail || status.rem_zero;
    assign result   = !status.too_low && status.bound_fail;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        is_prime_next = is_prime_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!finish) begin
                    cmd.next   = 1'b1;
                    state_next = ST_DIV;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    is_prime_next = result;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        is_prime_reg <= is_prime_next;
    end

    assign s_ready    = state_reg == ST_IDLE;
    assign m_valid    = m_valid_reg;
    assign m_is_prime = is_prime_reg;

endmodule

[hw/rtl/trial_division_prime_test_core.sv]
// divisors are tried in turn until one settles the candidate (only one for 0 and 1)
// each divisor runs NUM_WIDTH radix-2 restoring divider steps plus a decide state
// a new candidate is taken only in idle, after the previous one has finished
// a finished result waits in the output register while the next candidate is taken
// reset: synchronous, active low aresetn; returns to idle with no result pending
// top level: joins tdpt_ctrl and tdpt_datapath, depends on tdpt_pkg
module trial_division_prime_test_core #(
    parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [NUM_WIDTH-1:0] s_candidate,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_prime
);

    tdpt_pkg::cmd_t    cmd;
    tdpt_pkg::status_t status;

    tdpt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime),
        .cmd        (cmd),
        .status     (status)
    );

    tdpt_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_candidate (s_candidate),
        .cmd         (cmd),
        .status      (status)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready while a candidate is in progress");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a candidate in progress");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("controller not idle after delivering a result");
`endif

endmodule

[sim/testbench.sv]
// testbench for trial_division_prime_test_core: edge cases, prime squares, random candidates
// self-checking against an in-bench primality predictor; depends on tdpt_pkg and the core rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = tdpt_pkg::NUM_WIDTH_DEF;

    typedef struct {
        logic [NW-1:0] candidate;
        logic          is_prime;
    } verdict_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [NW-1:0] s_candidate = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_is_prime;

    verdict_t expected_verdicts[$];
    int       mismatch_count = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    trial_division_prime_test_core #(
        .NUM_WIDTH(NW)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_candidate(s_candidate),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

    always #6 aclk = ~aclk;

    function automatic logic candidate_is_prime(input logic [NW-1:0] n);
        longint unsigned v;
        longint unsigned d;
        v = n;
        if (v < tdpt_pkg::FIRST_DIVISOR) return 1'b0;
        for (d = tdpt_pkg::FIRST_DIVISOR; d <= v / d; d++) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [NW-1:0] prime_at_or_above(input logic [NW-1:0] start);
        logic [NW-1:0] p;
        p = start;
        while (!candidate_is_prime(p)) p++;
        return p;
    endfunction

    // mostly cheap candidates; wide values are forced to carry a small factor
    function automatic logic [NW-1:0] random_candidate();
        logic [NW-1:0] r;
        logic [NW-1:0] a;
        logic [NW-1:0] b;
        logic [NW-1:0] f;
        r = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                r = $urandom_range(0, 4095);
            end
            4, 5: begin
                r = $urandom_range(0, 1 << 20);
            end
            6, 7: begin
                r = $urandom;
                case ($urandom_range(0, 5))
                    0: f = 2;
                    1: f = 3;
                    2: f = 5;
                    3: f = 7;
                    4: f = 11;
                    default: f = 13;
                endcase
                r = r - (r % f);
            end
            8: begin
                a = prime_at_or_above($urandom_range(2, 1021));
                b = prime_at_or_above($urandom_range(2, 1021));
                r = a * b;
            end
            default: begin
                a = prime_at_or_above($urandom_range(2, 1021));
                r = a * a;
            end
        endcase
        return r;
    endfunction

    task automatic send_candidate(input logic [NW-1:0] value);
        verdict_t v;
        begin
            if ($urandom_range(0, 99) < send_idle_pct) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
            end
            s_valid     <= 1'b1;
            s_candidate <= value;
            do @(posedge aclk); while (!s_ready);
            v.candidate = value;
            v.is_prime  = candidate_is_prime(value);
            expected_verdicts.push_back(v);
            @(negedge aclk);
        end
    endtask

    task automatic test_edge_cases();
        logic [NW-1:0] values[$];
        begin
            values = '{0, 1, 2, 3, 4, 5, 65521, 65536, 1048573,
                       32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       32'hAAAA_AAAA, 32'h5555_5555};
            foreach (values[i]) send_candidate(values[i]);
        end
    endtask

    // divisor squared equal to the candidate is the bound's edge
    task automatic test_prime_squares();
        int primes[$];
        begin
            primes = '{2, 3, 5, 7, 11, 31, 251, 1021};
            foreach (primes[i]) send_candidate(primes[i] * primes[i]);
        end
    endtask

    task automatic test_random_candidates(input int count);
        begin
            repeat (count) send_candidate(random_candidate());
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected transaction, is_prime=%b", $realtime, m_is_prime);
                mismatch_count++;
            end else begin
                v = expected_verdicts.pop_front();
                if (m_is_prime !== v.is_prime) begin
                    $display("%0t: candidate %0d is_prime expected %b actual %b",
                             $realtime, v.candidate, v.is_prime, m_is_prime);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 37;
        recv_idle_pct = 77;
        test_edge_cases();
        test_random_candidates(26);

        send_idle_pct = 77;
        recv_idle_pct = 37;
        test_prime_squares();
        test_random_candidates(26);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_candidates(26);

        s_valid <= 1'b0;
        wait (expected_verdicts.size() == 0);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #250_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_datapath.sv
hw/rtl/tdpt_ctrl.sv
hw/rtl/trial_division_prime_test_core.sv
sim/testbench.sv
